@@ src/rssr_pkg.sv @@
// shared types and constants for the range sample smoother and reporter
package rssr_pkg;

  // ring depth and derived widths
  localparam int WINDOW = 10;
  localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SMP_W  = 13;
  localparam int SUM_W  = SMP_W + CNT_W;
  localparam int MS_W   = 32;
  localparam int IVL_W  = 16;
  localparam int RUN_W  = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VALID_FLOOR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEND_INTERVAL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INVALID_LIMIT = 2'd3;

  // register reset values
  localparam logic [SMP_W-1:0] FLOOR_RST    = 13'd8;
  localparam logic [SMP_W-1:0] DEADBAND_RST = 13'd16;
  localparam logic [IVL_W-1:0] INTERVAL_RST = 16'd200;
  localparam logic [RUN_W-1:0] LIMIT_RST    = 8'd5;
  localparam logic [RUN_W-1:0] RUN_MAX      = 8'd255;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_FIN
  } state_t;

endpackage

@@ src/rssr_div.sv @@
// restoring serial divider, one quotient bit per cycle
module rssr_div
  import rssr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [SMP_W-1:0] quotient
);

  localparam int BIT_W = $clog2(SUM_W + 1);

  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [SUM_W-1:0] quo_r, quo_nxt;
  logic [BIT_W-1:0] bits_r, bits_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W:0]   trial;
  logic             fits;

  // one shift and trial subtract per cycle
  always_comb begin
    trial    = {rem_r, quo_r[SUM_W-1]};
    fits     = trial >= {1'b0, divisor};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    bits_nxt = bits_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      bits_nxt = BIT_W'(SUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = fits ? CNT_W'(trial - {1'b0, divisor}) : trial[CNT_W-1:0];
      quo_nxt  = {quo_r[SUM_W-2:0], fits};
      bits_nxt = bits_r - 1'b1;
      if (bits_r == BIT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      bits_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      bits_r <= bits_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r[SMP_W-1:0];

endmodule

@@ src/range_sample_smoother_reporter_top.sv @@
// top level: validity gated moving average with deadband report
//
//  channel | ports                          | word
//  in      | in_tvalid in_tready in_tdata    | distance_sample, now_ms, link_ok
//  out     | out_tvalid out_tready out_tdata | mean, valid, shown, oor, send
//  cfg     | cfg_we cfg_index cfg_wdata      | one register per write
//
// a valid sample goes through the sum, divide and finish states: one
// shared adder walks the ring, then the serial divider gives one bit a cycle.
// an invalid sample goes from idle straight to finish. rst_n is synchronous
// and clears the ring. a new word is taken only when the sequencer is idle;
// a finished result waits in the output register while out_tready is low.
module range_sample_smoother_reporter_top
  import rssr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [12:0] distance_sample, [44:13] now_ms, [45] link_ok, [47:46] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [12:0] mean_value, [13] mean_valid, [26:14] shown_value,
  // [27] out_of_range, [28] send_now, [31:29] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DAT_W-1:0]   cfg_wdata
);

  state_t state_r, state_nxt;

  logic [SMP_W-1:0] floor_r, deadband_r;
  logic [IVL_W-1:0] interval_r;
  logic [RUN_W-1:0] limit_r;

  logic [SMP_W-1:0] ring_r [WINDOW];
  logic [IDX_W-1:0] slot_r;
  logic [IDX_W-1:0] idx_r;
  logic [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0] cnt_r;
  logic             valid_r;
  logic [MS_W-1:0]  now_r;
  logic             link_r;
  logic [SMP_W-1:0] mean_r;

  logic [SMP_W-1:0] held_r, last_rep_r;
  logic [RUN_W-1:0] run_r;
  logic             ever_r;
  logic [MS_W-1:0]  last_ms_r;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [SMP_W-1:0] in_sample;
  logic             in_acc, in_good, out_free, fin_go;
  logic             div_start, div_done;
  logic [SMP_W-1:0] div_q;
  logic [SMP_W-1:0] ring_rd, diff;
  logic [MS_W-1:0]  elapsed;
  logic [RUN_W-1:0] run_inc;
  logic             send, oor;

  assign in_sample = in_tdata[SMP_W-1:0];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_good   = in_sample > floor_r;
  assign out_free  = !out_valid_r || out_tready;
  assign fin_go    = (state_r == ST_FIN) && out_free;
  assign ring_rd   = ring_r[idx_r];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = in_good ? ST_SUM : ST_FIN;
      ST_SUM:  if (idx_r == IDX_W'(WINDOW - 1)) state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    div_start = (state_r == ST_SUM) && (idx_r == IDX_W'(WINDOW - 1));
  end

  rssr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r + ((ring_rd > floor_r) ? SUM_W'(ring_rd) : '0)),
    .divisor  (cnt_r + CNT_W'(ring_rd > floor_r)),
    .done     (div_done),
    .quotient (div_q)
  );

  // result of the finishing step
  always_comb begin
    diff    = (mean_r > last_rep_r) ? mean_r - last_rep_r : last_rep_r - mean_r;
    elapsed = now_r - last_ms_r;
    send    = valid_r && link_r && (!ever_r || diff > deadband_r) &&
              (elapsed > MS_W'(interval_r));
    run_inc = (run_r == RUN_MAX) ? run_r : run_r + 1'b1;
    oor     = !valid_r && (run_inc >= limit_r);
  end

  // control and persistent state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      floor_r     <= FLOOR_RST;
      deadband_r  <= DEADBAND_RST;
      interval_r  <= INTERVAL_RST;
      limit_r     <= LIMIT_RST;
      for (int i = 0; i < WINDOW; i++) ring_r[i] <= '0;
      slot_r      <= '0;
      held_r      <= '0;
      run_r       <= '0;
      last_rep_r  <= '0;
      ever_r      <= 1'b0;
      last_ms_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_VALID_FLOOR:   floor_r    <= cfg_wdata[SMP_W-1:0];
          REG_DEADBAND:      deadband_r <= cfg_wdata[SMP_W-1:0];
          REG_SEND_INTERVAL: interval_r <= cfg_wdata[IVL_W-1:0];
          REG_INVALID_LIMIT: limit_r    <= cfg_wdata[RUN_W-1:0];
          default: ;
        endcase
      end
      // store a valid sample into the ring
      if (in_acc && in_good) begin
        ring_r[slot_r] <= in_sample;
        slot_r <= (slot_r == IDX_W'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
      end
      // commit the result
      if (fin_go) begin
        if (valid_r) begin
          held_r <= mean_r;
          run_r  <= '0;
        end else begin
          run_r  <= run_inc;
        end
        if (send) begin
          last_rep_r <= mean_r;
          last_ms_r  <= now_r;
          ever_r     <= 1'b1;
        end
      end
      if (fin_go) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      now_r   <= in_tdata[SMP_W +: MS_W];
      link_r  <= in_tdata[SMP_W + MS_W];
      valid_r <= in_good;
      mean_r  <= '0;
      idx_r   <= '0;
      sum_r   <= '0;
      cnt_r   <= '0;
    end
    // shared adder walks the ring
    if (state_r == ST_SUM) begin
      if (ring_rd > floor_r) begin
        sum_r <= sum_r + SUM_W'(ring_rd);
        cnt_r <= cnt_r + 1'b1;
      end
      idx_r <= idx_r + 1'b1;
    end
    if (state_r == ST_DIV && div_done) mean_r <= div_q;
    if (fin_go) begin
      out_data_r <= {3'b000, send, oor, valid_r ? mean_r : held_r, valid_r, mean_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // an invalid word never reports and never carries a mean
  a_invalid_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[13] |-> !out_tdata[28] && out_tdata[12:0] == '0)
    else $error("invalid word carries a mean or a send");

  // out of range only on invalid words
  a_oor_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[27] |-> !out_tdata[13])
    else $error("out of range on a valid word");

  // the ring write pointer stays inside the window
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= IDX_W'(WINDOW - 1))
    else $error("write slot beyond window");

  // an accepted word keeps the sequencer busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("ready right after accept");

endmodule

@@ sim/tb.sv @@
// testbench for the range sample smoother and reporter top level
module tb;
  import rssr_pkg::*;

  localparam int LATENCY_CYCLES = 1 + WINDOW + SUM_W + 2;
  localparam int STALL_LIMIT    = 3000;

  // one result word split into its fields
  typedef struct packed {
    logic [SMP_W-1:0] mean;
    logic             valid;
    logic [SMP_W-1:0] shown;
    logic             oor;
    logic             send;
  } range_report_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // [12:0] distance_sample, [44:13] now_ms, [45] link_ok, [47:46] zero
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [12:0] mean_value, [13] mean_valid, [26:14] shown_value,
  // [27] out_of_range, [28] send_now, [31:29] zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DAT_W-1:0]   cfg_wdata = '0;

  range_sample_smoother_reporter_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // expected reports, oldest first
  range_report_t pending_reports[$];
  int            err_count = 0;
  int            send_gap_pct = 0;
  int            ready_gap_pct = 0;
  int            idle_cycles = 0;
  logic [31:0]   stamp_ms = '0;

  // smoother model state and thresholds
  logic [SMP_W-1:0] ring_mem [WINDOW];
  int unsigned      ring_slot;
  logic [SMP_W-1:0] hold_mean;
  int unsigned      bad_run;
  logic [SMP_W-1:0] sent_mean;
  logic             sent_once;
  logic [31:0]      sent_stamp;
  logic [SMP_W-1:0] floor_thr;
  logic [SMP_W-1:0] band_thr;
  logic [IVL_W-1:0] gap_thr;
  logic [RUN_W-1:0] limit_thr;

  initial begin
    forever #5 clk = ~clk;
  end

  // model state after reset
  task automatic clear_smoother_model();
    for (int i = 0; i < WINDOW; i++) ring_mem[i] = '0;
    ring_slot  = 0;
    hold_mean  = '0;
    bad_run    = 0;
    sent_mean  = '0;
    sent_once  = 1'b0;
    sent_stamp = '0;
    floor_thr  = FLOOR_RST;
    band_thr   = DEADBAND_RST;
    gap_thr    = INTERVAL_RST;
    limit_thr  = LIMIT_RST;
  endtask

  // windowed mean, hold, invalid run and report decision for one sample
  function automatic range_report_t predict_report(logic [SMP_W-1:0] smp,
                                                   logic [31:0] now, logic link);
    range_report_t r;
    int unsigned   sum;
    int unsigned   cnt;
    int unsigned   diff;
    logic [31:0]   elapsed;
    r   = '0;
    sum = 0;
    cnt = 0;
    if (smp > floor_thr) begin
      ring_mem[ring_slot] = smp;
      ring_slot = (ring_slot + 1 >= WINDOW) ? 0 : ring_slot + 1;
      for (int i = 0; i < WINDOW; i++) begin
        if (ring_mem[i] > floor_thr) begin
          sum += ring_mem[i];
          cnt++;
        end
      end
      if (cnt != 0) begin
        r.mean  = SMP_W'(sum / cnt);
        r.valid = 1'b1;
      end
    end
    if (r.valid) begin
      hold_mean = r.mean;
      bad_run   = 0;
      r.shown   = r.mean;
      diff      = (r.mean > sent_mean) ? r.mean - sent_mean : sent_mean - r.mean;
      elapsed   = now - sent_stamp;
      if (link && (!sent_once || diff > band_thr) && elapsed > {16'd0, gap_thr}) begin
        r.send     = 1'b1;
        sent_mean  = r.mean;
        sent_stamp = now;
        sent_once  = 1'b1;
      end
    end else begin
      if (bad_run < RUN_MAX) bad_run++;
      r.oor   = (bad_run >= limit_thr);
      r.shown = hold_mean;
    end
    return r;
  endfunction

  // send one sample word, predict on acceptance
  task automatic push_sample(logic [SMP_W-1:0] smp, logic [31:0] now, logic link);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, link, now, smp};
    do @(posedge clk); while (!in_tready);
    pending_reports.push_back(predict_report(smp, now, link));
  endtask

  // stop sending and wait for every outstanding report
  task automatic wait_all_reports();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // one register write, block must be idle
  task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_VALID_FLOOR:   floor_thr = val[SMP_W-1:0];
      REG_DEADBAND:      band_thr  = val[SMP_W-1:0];
      REG_SEND_INTERVAL: gap_thr   = val[IVL_W-1:0];
      REG_INVALID_LIMIT: limit_thr = val[RUN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_thresholds(int flr, int band, int gap, int lim);
    wait_all_reports();
    set_register(REG_VALID_FLOOR, CFG_DAT_W'(flr));
    set_register(REG_DEADBAND, CFG_DAT_W'(band));
    set_register(REG_SEND_INTERVAL, CFG_DAT_W'(gap));
    set_register(REG_INVALID_LIMIT, CFG_DAT_W'(lim));
  endtask

  task automatic load_random_thresholds();
    load_thresholds($urandom_range(0, 2000), $urandom_range(0, 400),
                    $urandom_range(0, 1000), $urandom_range(1, 12));
  endtask

  // default thresholds: floor edge, first report, deadband, interval, link, wrap
  task automatic test_reset_defaults();
    push_sample(13'd0, 32'd0, 1'b1);
    push_sample(13'd8, 32'd10, 1'b1);
    push_sample(13'd9, 32'd100, 1'b1);
    push_sample(13'd8191, 32'd201, 1'b1);
    push_sample(13'd4110, 32'd300, 1'b1);
    // elapsed equal to the interval does not report
    push_sample(13'd20, 32'd401, 1'b1);
    push_sample(13'd20, 32'd402, 1'b0);
    push_sample(13'd20, 32'd403, 1'b1);
    // invalid run reaching the limit
    repeat (5) push_sample(13'd3, 32'd500, 1'b1);
    push_sample(13'd8191, 32'hFFFF_FF00, 1'b1);
    push_sample(13'd9, 32'h0000_0010, 1'b1);
  endtask

  // register extremes, floor raised over stored entries, limit zero
  task automatic test_register_extremes();
    load_thresholds(0, 0, 0, 0);
    push_sample(13'd0, 32'd1000, 1'b1);
    push_sample(13'd1, 32'd1001, 1'b1);
    push_sample(13'd1, 32'd1001, 1'b1);
    load_thresholds(5000, 8191, 65535, 1);
    push_sample(13'd6000, 32'd1002, 1'b1);
    push_sample(13'd4000, 32'd1003, 1'b1);
    load_thresholds(8191, 16, 200, 255);
    push_sample(13'd8191, 32'd1004, 1'b1);
    load_thresholds(8, 16, 200, 5);
    stamp_ms = 32'd1004;
  endtask

  // long invalid run so the counter saturates
  task automatic test_invalid_saturation();
    load_thresholds(100, 16, 200, 255);
    repeat (262) begin
      stamp_ms += $urandom_range(0, 50);
      push_sample(SMP_W'($urandom_range(0, 100)), stamp_ms, 1'($urandom_range(1)));
    end
    push_sample(13'd500, stamp_ms, 1'b1);
    push_sample(13'd50, stamp_ms, 1'b1);
  endtask

  // mostly steady valid traffic with jitter, plus invalid and noise words
  task automatic test_random_traffic(int n_words);
    int          level;
    int          smp;
    int          pick;
    logic        link;
    level = $urandom_range(floor_thr + 1, 8191);
    for (int k = 0; k < n_words; k++) begin
      pick = $urandom_range(99);
      if ($urandom_range(99) < 10) level = $urandom_range(floor_thr + 1, 8191);
      if (pick < 70) begin
        smp = level + $urandom_range(0, 80) - 40;
        if (smp <= floor_thr) smp = floor_thr + 1;
        if (smp > 8191) smp = 8191;
      end else if (pick < 85) begin
        smp = $urandom_range(0, floor_thr);
      end else if (pick < 92) begin
        smp = $urandom_range(0, 8191);
      end else begin
        smp = $urandom_range(1) ? 8191 : 0;
      end
      if ($urandom_range(99) < 5) stamp_ms = $urandom;
      else stamp_ms += $urandom_range(0, 2 * gap_thr + 20);
      link = ($urandom_range(99) < 90);
      push_sample(SMP_W'(smp), stamp_ms, link);
      // occasional hold-off until the pipe is empty
      if ($urandom_range(99) < 2) wait_all_reports();
    end
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= ready_gap_pct);
  end

  // compare each result word with the oldest expectation
  always @(posedge clk) begin
    range_report_t got;
    range_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.mean  = out_tdata[12:0];
      got.valid = out_tdata[13];
      got.shown = out_tdata[26:14];
      got.oor   = out_tdata[27];
      got.send  = out_tdata[28];
      if (pending_reports.size() == 0) begin
        $error("result word with nothing expected: %h", out_tdata);
        err_count++;
      end else begin
        want = pending_reports.pop_front();
        if (got.mean !== want.mean) begin
          $error("mean_value: expected %0d, got %0d", want.mean, got.mean);
          err_count++;
        end
        if (got.valid !== want.valid) begin
          $error("mean_valid: expected %0d, got %0d", want.valid, got.valid);
          err_count++;
        end
        if (got.shown !== want.shown) begin
          $error("shown_value: expected %0d, got %0d", want.shown, got.shown);
          err_count++;
        end
        if (got.oor !== want.oor) begin
          $error("out_of_range: expected %0d, got %0d", want.oor, got.oor);
          err_count++;
        end
        if (got.send !== want.send) begin
          $error("send_now: expected %0d, got %0d", want.send, got.send);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL range_sample_smoother_reporter_top");
        $finish;
      end
    end
  end

  initial begin
    clear_smoother_model();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_gap_pct  = 30;
    ready_gap_pct = 82;
    test_reset_defaults();
    test_register_extremes();
    test_invalid_saturation();
    load_random_thresholds();
    test_random_traffic(36);
    load_thresholds(0, 0, 0, 1);
    test_random_traffic(36);

    send_gap_pct  = 82;
    ready_gap_pct = 30;
    load_thresholds($urandom_range(4000, 8000), 8191, 65535, 255);
    test_random_traffic(36);
    load_random_thresholds();
    test_random_traffic(36);

    send_gap_pct  = 0;
    ready_gap_pct = 0;
    load_random_thresholds();
    test_random_traffic(36);
    load_thresholds(0, 0, 0, 1);
    test_random_traffic(36);

    // drain and let the block settle
    wait_all_reports();
    repeat (4 * LATENCY_CYCLES) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $error("%0d expected reports never arrived", pending_reports.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("PASS range_sample_smoother_reporter_top");
    end else begin
      $display("FAIL range_sample_smoother_reporter_top");
    end
    $finish;
  end

endmodule
